[rtl/core/cfsd_pkg.sv]
`default_nettype none
package cfsd_pkg;

    localparam int MAX_SERVERS   = 16;
    localparam int IDX_BITS      = 4;
    localparam int NSRV_BITS     = 5;
    localparam int CNT_BITS      = 16;
    localparam int TIME_BITS     = 31;
    localparam int BUSY_BITS     = 32;
    localparam int S_TDATA_BITS  = 64;
    localparam int M_TDATA_BITS  = 24;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_NUM_SERVERS = '0;
    localparam logic [NSRV_BITS-1:0]     NUM_SERVERS_RST  = NSRV_BITS'(MAX_SERVERS);
    localparam logic [CNT_BITS-1:0]      CNT_CAP          = '1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_LIST    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_OUTCOME,
        ST_LIST,
        ST_CLEAR
    } cfsd_state_t;

    typedef struct packed {
        logic capture;
        logic search;
        logic update;
        logic load_outcome;
        logic load_entry;
        logic scan_clr;
        logic scan_inc;
        logic clear;
    } cfsd_cmd_t;

    typedef struct packed {
        logic eob;
        logic none_active;
        logic scan_match;
        logic scan_last;
        logic out_free;
    } cfsd_status_t;

    function automatic logic [NSRV_BITS-1:0] active_count(input logic [NSRV_BITS-1:0] ns);
        logic [NSRV_BITS-1:0] n;
        if (ns == '0) begin
            n = NSRV_BITS'(1);
        end else if (ns > NSRV_BITS'(MAX_SERVERS)) begin
            n = NSRV_BITS'(MAX_SERVERS);
        end else begin
            n = ns;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/core/cfsd_ctrl.sv]
`default_nettype none
module cfsd_ctrl
    import cfsd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire cfsd_status_t status,
    output cfsd_cmd_t         cmd
);

    cfsd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OUTCOME;
            end
            ST_OUTCOME: begin
                if (status.out_free) begin
                    cmd.load_outcome = 1'b1;
                    if (!status.eob) begin
                        state_next = ST_IDLE;
                    end else if (status.none_active) begin
                        state_next = ST_CLEAR;
                    end else begin
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_LIST;
                    end
                end
            end
            ST_LIST: begin
                if (status.out_free) begin
                    if (status.scan_match) begin
                        cmd.load_entry = 1'b1;
                        if (status.scan_last) begin
                            state_next = ST_CLEAR;
                        end else begin
                            cmd.scan_inc = 1'b1;
                        end
                    end else begin
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/cfsd_datapath.sv]
`default_nettype none
module cfsd_datapath
    import cfsd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cfsd_cmd_t               cmd,
    output cfsd_status_t                 status,
    input  wire logic [NSRV_BITS-1:0]    num_servers,
    input  wire logic [S_TDATA_BITS-1:0] in_data,
    input  wire logic                    in_last,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [M_TDATA_BITS-1:0]      out_data,
    output logic                         out_user,
    output logic                         out_last
);

    logic [TIME_BITS-1:0] arrival_reg, load_reg;
    logic                 eob_reg;
    logic [BUSY_BITS-1:0] busy_reg [MAX_SERVERS];
    logic [CNT_BITS-1:0]  cnt_reg  [MAX_SERVERS];
    logic [CNT_BITS-1:0]  max_reg;
    logic [IDX_BITS-1:0]  slot_reg;
    logic [IDX_BITS-1:0]  chosen_reg;
    logic                 found_reg;
    logic [IDX_BITS-1:0]  scan_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;
    logic                 out_user_reg, out_last_reg;

    logic [NSRV_BITS-1:0]   n;
    logic [IDX_BITS-1:0]    start;
    logic [MAX_SERVERS-1:0] free_vec, hi_vec, match_vec, later_vec;
    logic [IDX_BITS-1:0]    first_hi, first_any;
    logic [IDX_BITS-1:0]    rd_idx;
    logic [CNT_BITS-1:0]    rd_cnt, cnt_inc;
    logic [IDX_BITS-1:0]    slot_inc;
    logic                   out_free;

    assign n        = active_count(num_servers);
    assign start    = ({1'b0, slot_reg} < n) ? slot_reg : '0;
    assign slot_inc = ({1'b0, start} + NSRV_BITS'(1) >= n) ? '0 : start + IDX_BITS'(1);
    assign rd_idx   = cmd.load_entry ? scan_reg : chosen_reg;
    assign rd_cnt   = cnt_reg[rd_idx];
    assign cnt_inc  = (rd_cnt == CNT_CAP) ? rd_cnt : rd_cnt + CNT_BITS'(1);
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        for (int j = 0; j < MAX_SERVERS; j++) begin
            free_vec[j]  = (busy_reg[j] <= {1'b0, arrival_reg}) && (NSRV_BITS'(j) < n);
            hi_vec[j]    = free_vec[j] && (IDX_BITS'(j) >= start);
            match_vec[j] = (cnt_reg[j] == max_reg) && (NSRV_BITS'(j) < n);
            later_vec[j] = match_vec[j] && (IDX_BITS'(j) > scan_reg);
        end
        first_hi  = '0;
        first_any = '0;
        for (int j = MAX_SERVERS - 1; j >= 0; j--) begin
            if (hi_vec[j]) begin
                first_hi = IDX_BITS'(j);
            end
            if (free_vec[j]) begin
                first_any = IDX_BITS'(j);
            end
        end
    end

    assign status.eob         = eob_reg;
    assign status.none_active = (match_vec == '0);
    assign status.scan_match  = match_vec[scan_reg];
    assign status.scan_last   = (later_vec == '0);
    assign status.out_free    = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            arrival_reg <= in_data[TIME_BITS-1:0];
            load_reg    <= in_data[2*TIME_BITS-1:TIME_BITS];
            eob_reg     <= in_last;
        end
        if (cmd.search) begin
            chosen_reg <= (hi_vec != '0) ? first_hi : first_any;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
        end else if (cmd.scan_inc) begin
            scan_reg <= scan_reg + IDX_BITS'(1);
        end
        if (cmd.load_outcome) begin
            out_user_reg <= KIND_REQUEST;
            out_last_reg <= !eob_reg || (match_vec == '0);
            out_data_reg <= {3'b000,
                             found_reg ? rd_cnt : CNT_BITS'(0),
                             !found_reg,
                             found_reg ? chosen_reg : IDX_BITS'(0)};
        end else if (cmd.load_entry) begin
            out_user_reg <= KIND_LIST;
            out_last_reg <= (later_vec == '0);
            out_data_reg <= {3'b000, rd_cnt, 1'b0, scan_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (cmd.load_outcome || cmd.load_entry) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.search) begin
                found_reg <= (free_vec != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int j = 0; j < MAX_SERVERS; j++) begin
                busy_reg[j] <= '0;
                cnt_reg[j]  <= '0;
            end
            max_reg  <= '0;
            slot_reg <= '0;
        end else if (cmd.update) begin
            slot_reg <= slot_inc;
            if (found_reg) begin
                busy_reg[chosen_reg] <= {1'b0, arrival_reg} + {1'b0, load_reg};
                cnt_reg[chosen_reg]  <= cnt_inc;
                if (cnt_inc > max_reg) begin
                    max_reg <= cnt_inc;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

[rtl/core/circular_free_server_dispatch.sv]
// An accepted word moves through the search, update and outcome states to its outcome word on
// m_tvalid (the outcome state waits for a free output). Each request runs capture, circular search over
// the busy-until comparators, state update and outcome load; no new word is taken until it is done.
// An end-of-batch word adds a list of the servers holding the highest handled count (if any) and a clear step.
// Reset (aresetn low, synchronous): all busy times, counts, max and slot clear,
// num_servers returns to 16.
`default_nettype none
module circular_free_server_dispatch
    import cfsd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // arrival_time, load_time, zero pad
    input  wire logic                     s_tlast,   // end_of_batch
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,   // server_index, dropped, handled_count, pad
    output logic                          m_tuser,   // entry_kind
    output logic                          m_tlast,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    logic [NSRV_BITS-1:0] num_servers_reg;
    cfsd_cmd_t            cmd;
    cfsd_status_t         status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NUM_SERVERS) ?
                    {{(APB_DATA_BITS-NSRV_BITS){1'b0}}, num_servers_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_servers_reg <= NUM_SERVERS_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_NUM_SERVERS) begin
            num_servers_reg <= pwdata[NSRV_BITS-1:0];
        end
    end

    cfsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfsd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .num_servers (num_servers_reg),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_user    (m_tuser),
        .out_last    (m_tlast)
    );

endmodule
`default_nettype wire
